### hdl/ecv_pkg.sv
// shared types, fixed-point constants and rounding for the easing curve evaluator
package ecv_pkg;

  localparam int FRAC_BITS = 15;
  localparam int POS_W     = 16;
  localparam int CURVE_W   = 4;
  localparam int EASED_W   = 17;
  // working width: room for values up to about 16.0 plus sign, never below the result width
  localparam int DW        = (FRAC_BITS + 5 > EASED_W) ? FRAC_BITS + 5 : EASED_W;
  localparam int PW        = 2 * DW;

  typedef logic signed [DW-1:0] q_t;
  typedef logic signed [PW-1:0] prod_t;

  typedef enum logic [CURVE_W-1:0] {
    CRV_NONE       = 4'd0,
    CRV_LINEAR     = 4'd1,
    CRV_EASE_IN    = 4'd2,
    CRV_EASE_OUT   = 4'd3,
    CRV_EASE_BOTH  = 4'd4,
    CRV_BOUNCE_IN  = 4'd5,
    CRV_BOUNCE_OUT = 4'd6,
    CRV_SPRING_IN  = 4'd7,
    CRV_SPRING_OUT = 4'd8
  } curve_t;

  // control that travels with each word down the pipeline
  typedef struct packed {
    curve_t     curve;
    logic       alt;
    logic [1:0] seg;
  } ctl_t;

  localparam q_t Q_ZERO   = q_t'(0);
  localparam q_t Q_LSB    = q_t'(1);
  localparam q_t Q_ONE    = q_t'(1 << FRAC_BITS);
  localparam q_t Q_HALF   = q_t'(1 << (FRAC_BITS - 1));
  localparam q_t Q_4_11   = q_t'(((4 << FRAC_BITS) + 11 / 2) / 11);
  localparam q_t Q_6_11   = q_t'(((6 << FRAC_BITS) + 11 / 2) / 11);
  localparam q_t Q_8_11   = q_t'(((8 << FRAC_BITS) + 11 / 2) / 11);
  localparam q_t Q_9_11   = q_t'(((9 << FRAC_BITS) + 11 / 2) / 11);
  localparam q_t Q_10_11  = q_t'(((10 << FRAC_BITS) + 11 / 2) / 11);
  localparam q_t Q_21_22  = q_t'(((21 << FRAC_BITS) + 22 / 2) / 22);
  localparam q_t Q_3_4    = q_t'(((3 << FRAC_BITS) + 4 / 2) / 4);
  localparam q_t Q_15_16  = q_t'(((15 << FRAC_BITS) + 16 / 2) / 16);
  localparam q_t Q_63_64  = q_t'(((63 << FRAC_BITS) + 64 / 2) / 64);
  localparam q_t Q_121_16 = q_t'(((121 << FRAC_BITS) + 16 / 2) / 16);
  localparam q_t Q_3_10   = q_t'(((3 << FRAC_BITS) + 10 / 2) / 10);
  localparam q_t Q_10_3   = q_t'(((10 << FRAC_BITS) + 3 / 2) / 3);
  localparam q_t Q_10_7   = q_t'(((10 << FRAC_BITS) + 7 / 2) / 7);
  localparam q_t Q_13_10  = q_t'(((13 << FRAC_BITS) + 10 / 2) / 10);

  localparam prod_t P_HALF = prod_t'(1 << (FRAC_BITS - 1));

  // round a raw product back to the working format, halves away from zero
  function automatic q_t qround(input prod_t p);
    prod_t mag;
    prod_t sh;
    mag = p[PW-1] ? -p : p;
    sh  = (mag + P_HALF) >>> FRAC_BITS;
    return p[PW-1] ? q_t'(-sh) : q_t'(sh);
  endfunction

endpackage

### hdl/ecv_mul.sv
// registered multiply stage: full product plus the control that rides along
module ecv_mul (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_in,
  input  ecv_pkg::ctl_t ctl_in,
  input  ecv_pkg::q_t   a_in,
  input  ecv_pkg::q_t   b_in,
  output logic          valid_out,
  output ecv_pkg::ctl_t ctl_out,
  output ecv_pkg::prod_t prod_out
);

  logic           valid_r;
  ecv_pkg::ctl_t  ctl_r;
  ecv_pkg::prod_t prod_r;
  ecv_pkg::prod_t prod_nxt;

  assign prod_nxt = ecv_pkg::prod_t'(a_in) * ecv_pkg::prod_t'(b_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    ctl_r  <= ctl_in;
    prod_r <= prod_nxt;
  end

  assign valid_out = valid_r;
  assign ctl_out   = ctl_r;
  assign prod_out  = prod_r;

endmodule

### hdl/easing_curve_evaluator.sv
// top level of the easing curve evaluator: seven-stage fixed-point pipeline
//
// A word (in_position, in_curve) is taken on every clock edge where start is
// high; busy stays low, so one word per cycle is sustained with no gaps. The
// eased value comes out on out_eased, marked by a one-cycle out_valid strobe,
// in the same order the words went in. Every curve is mapped onto three
// chained multiplies, in the stages operand select, multiply, round-and-select,
// multiply, round-and-select, multiply, final round and combine. Curves that
// need fewer multiplies pass through the spare ones as a multiply by 1.0,
// which is exact. There is no state between words and no backpressure: the
// receiver must take each result in the cycle it is shown. Position above 1.0
// is saturated to 1.0.
module easing_curve_evaluator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [ecv_pkg::POS_W-1:0]           in_position,
  input  logic [ecv_pkg::CURVE_W-1:0]         in_curve,
  output logic                                out_valid,
  output logic signed [ecv_pkg::EASED_W-1:0]  out_eased
);

  // every stage moves each cycle, nothing ever holds the input off
  assign busy = 1'b0;

  // ---------------- stage 1: saturate, pick curve input, first operands
  ecv_pkg::q_t    pos_ext;
  ecv_pkg::q_t    t_sat;
  ecv_pkg::q_t    inv;
  ecv_pkg::q_t    x;
  ecv_pkg::q_t    centre;
  ecv_pkg::q_t    d;
  ecv_pkg::curve_t crv;
  ecv_pkg::ctl_t  c1_nxt;
  ecv_pkg::q_t    a1_nxt;
  ecv_pkg::q_t    b1_nxt;

  logic           v1_r;
  ecv_pkg::ctl_t  c1_r;
  ecv_pkg::q_t    a1_r;
  ecv_pkg::q_t    b1_r;

  always_comb begin
    crv     = ecv_pkg::curve_t'(in_curve);
    pos_ext = ecv_pkg::q_t'(in_position);
    t_sat   = (pos_ext > ecv_pkg::Q_ONE) ? ecv_pkg::Q_ONE : pos_ext;
    inv     = ecv_pkg::Q_ONE - t_sat;
    // mirrored curves run the base curve on 1 - t
    x       = (crv == ecv_pkg::CRV_BOUNCE_IN || crv == ecv_pkg::CRV_SPRING_OUT) ? inv : t_sat;

    // bounce segment and its parabola centre
    if (x < ecv_pkg::Q_4_11) begin
      c1_nxt.seg = 2'd0;
      centre     = ecv_pkg::Q_ZERO;
    end else if (x < ecv_pkg::Q_8_11) begin
      c1_nxt.seg = 2'd1;
      centre     = ecv_pkg::Q_6_11;
    end else if (x < ecv_pkg::Q_10_11) begin
      c1_nxt.seg = 2'd2;
      centre     = ecv_pkg::Q_9_11;
    end else begin
      c1_nxt.seg = 2'd3;
      centre     = ecv_pkg::Q_21_22;
    end
    d = x - centre;

    c1_nxt.curve = crv;
    // alt: lower half for ease both, wind-up part for the springs
    if (crv == ecv_pkg::CRV_EASE_BOTH) begin
      c1_nxt.alt = (t_sat < ecv_pkg::Q_HALF);
    end else begin
      c1_nxt.alt = (x < ecv_pkg::Q_3_10);
    end

    case (crv)
      ecv_pkg::CRV_NONE: begin
        a1_nxt = ecv_pkg::Q_ZERO;
        b1_nxt = ecv_pkg::Q_ZERO;
      end
      ecv_pkg::CRV_EASE_IN: begin
        a1_nxt = t_sat;
        b1_nxt = t_sat;
      end
      ecv_pkg::CRV_EASE_OUT: begin
        a1_nxt = inv;
        b1_nxt = inv;
      end
      ecv_pkg::CRV_EASE_BOTH: begin
        // upper half: 1 - 2(t - 0.5) is just 2(1 - t)
        if (c1_nxt.alt) begin
          a1_nxt = t_sat <<< 1;
          b1_nxt = t_sat;
        end else begin
          a1_nxt = inv <<< 1;
          b1_nxt = inv <<< 1;
        end
      end
      ecv_pkg::CRV_BOUNCE_IN, ecv_pkg::CRV_BOUNCE_OUT: begin
        a1_nxt = d;
        b1_nxt = d;
      end
      ecv_pkg::CRV_SPRING_IN, ecv_pkg::CRV_SPRING_OUT: begin
        if (c1_nxt.alt) begin
          a1_nxt = x;
          b1_nxt = ecv_pkg::Q_10_3;
        end else begin
          a1_nxt = x - ecv_pkg::Q_3_10;
          b1_nxt = ecv_pkg::Q_10_7;
        end
      end
      default: begin
        // linear and unused codes: t times one
        a1_nxt = t_sat;
        b1_nxt = ecv_pkg::Q_ONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    c1_r <= c1_nxt;
    a1_r <= a1_nxt;
    b1_r <= b1_nxt;
  end

  // ---------------- stage 2: first multiply
  logic           vm1;
  ecv_pkg::ctl_t  cm1;
  ecv_pkg::prod_t p1;

  ecv_mul u_mul1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (v1_r),
    .ctl_in    (c1_r),
    .a_in      (a1_r),
    .b_in      (b1_r),
    .valid_out (vm1),
    .ctl_out   (cm1),
    .prod_out  (p1)
  );

  // ---------------- stage 3: round, second operands
  ecv_pkg::q_t   m1;
  ecv_pkg::q_t   a2_nxt;
  ecv_pkg::q_t   b2_nxt;
  logic          v2_r;
  ecv_pkg::ctl_t c2_r;
  ecv_pkg::q_t   a2_r;
  ecv_pkg::q_t   b2_r;

  always_comb begin
    m1 = ecv_pkg::qround(p1);
    case (cm1.curve)
      ecv_pkg::CRV_BOUNCE_IN, ecv_pkg::CRV_BOUNCE_OUT: begin
        a2_nxt = m1;
        b2_nxt = ecv_pkg::Q_121_16;
      end
      ecv_pkg::CRV_SPRING_IN, ecv_pkg::CRV_SPRING_OUT: begin
        // wind-up squares 1 - r, the main swing squares r
        if (cm1.alt) begin
          a2_nxt = ecv_pkg::Q_ONE - m1;
          b2_nxt = ecv_pkg::Q_ONE - m1;
        end else begin
          a2_nxt = m1;
          b2_nxt = m1;
        end
      end
      default: begin
        a2_nxt = m1;
        b2_nxt = ecv_pkg::Q_ONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= vm1;
    end
  end

  always_ff @(posedge clk) begin
    c2_r <= cm1;
    a2_r <= a2_nxt;
    b2_r <= b2_nxt;
  end

  // ---------------- stage 4: second multiply
  logic           vm2;
  ecv_pkg::ctl_t  cm2;
  ecv_pkg::prod_t p2;

  ecv_mul u_mul2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (v2_r),
    .ctl_in    (c2_r),
    .a_in      (a2_r),
    .b_in      (b2_r),
    .valid_out (vm2),
    .ctl_out   (cm2),
    .prod_out  (p2)
  );

  // ---------------- stage 5: round, third operands
  ecv_pkg::q_t   m2;
  ecv_pkg::q_t   a3_nxt;
  ecv_pkg::q_t   b3_nxt;
  logic          v3_r;
  ecv_pkg::ctl_t c3_r;
  ecv_pkg::q_t   a3_r;
  ecv_pkg::q_t   b3_r;

  always_comb begin
    m2 = ecv_pkg::qround(p2);
    case (cm2.curve)
      ecv_pkg::CRV_SPRING_IN, ecv_pkg::CRV_SPRING_OUT: begin
        // scale to the -0.3 dip or to the 1.3 span
        if (cm2.alt) begin
          a3_nxt = ecv_pkg::Q_ONE - m2;
          b3_nxt = ecv_pkg::Q_3_10;
        end else begin
          a3_nxt = m2;
          b3_nxt = ecv_pkg::Q_13_10;
        end
      end
      default: begin
        a3_nxt = m2;
        b3_nxt = ecv_pkg::Q_ONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= vm2;
    end
  end

  always_ff @(posedge clk) begin
    c3_r <= cm2;
    a3_r <= a3_nxt;
    b3_r <= b3_nxt;
  end

  // ---------------- stage 6: third multiply
  logic           vm3;
  ecv_pkg::ctl_t  cm3;
  ecv_pkg::prod_t p3;

  ecv_mul u_mul3 (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (v3_r),
    .ctl_in    (c3_r),
    .a_in      (a3_r),
    .b_in      (b3_r),
    .valid_out (vm3),
    .ctl_out   (cm3),
    .prod_out  (p3)
  );

  // ---------------- stage 7: round, lift or mirror, output register
  ecv_pkg::q_t m3;
  ecv_pkg::q_t lift;
  ecv_pkg::q_t bnc;
  ecv_pkg::q_t spr;
  ecv_pkg::q_t res;

  logic                               out_valid_r;
  logic signed [ecv_pkg::EASED_W-1:0] out_eased_r;

  always_comb begin
    m3 = ecv_pkg::qround(p3);
    case (cm3.seg)
      2'd0:    lift = ecv_pkg::Q_ZERO;
      2'd1:    lift = ecv_pkg::Q_3_4;
      2'd2:    lift = ecv_pkg::Q_15_16;
      default: lift = ecv_pkg::Q_63_64;
    endcase
    bnc = m3 + lift;
    spr = cm3.alt ? -m3 : m3 - ecv_pkg::Q_3_10;

    case (cm3.curve)
      ecv_pkg::CRV_NONE:       res = ecv_pkg::Q_ZERO;
      ecv_pkg::CRV_EASE_OUT:   res = ecv_pkg::Q_ONE - m3;
      ecv_pkg::CRV_EASE_BOTH: begin
        // upper half: halve 1 - square with rounding, then add one half
        if (cm3.alt) begin
          res = m3;
        end else begin
          res = ((ecv_pkg::Q_ONE - m3 + ecv_pkg::Q_LSB) >>> 1) + ecv_pkg::Q_HALF;
        end
      end
      ecv_pkg::CRV_BOUNCE_IN:  res = ecv_pkg::Q_ONE - bnc;
      ecv_pkg::CRV_BOUNCE_OUT: res = bnc;
      ecv_pkg::CRV_SPRING_IN:  res = spr;
      ecv_pkg::CRV_SPRING_OUT: res = ecv_pkg::Q_ONE - spr;
      default:                 res = m3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vm3;
    end
  end

  always_ff @(posedge clk) begin
    out_eased_r <= res[ecv_pkg::EASED_W-1:0];
  end

  assign out_valid = out_valid_r;
  assign out_eased = out_eased_r;

endmodule

### hdl/ecv_checker.sv
// port-level checks for the easing curve evaluator, bound to the top level
module ecv_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic [ecv_pkg::POS_W-1:0]           in_position,
  input logic [ecv_pkg::CURVE_W-1:0]         in_curve,
  input logic                                out_valid,
  input logic signed [ecv_pkg::EASED_W-1:0]  out_eased
);


  a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##7 out_valid)
    else $error("accepted word did not come out after 7 cycles");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 7))
    else $error("result strobe without a matching accepted word");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_curve == ecv_pkg::CRV_NONE) |-> ##7 (out_eased == '0))
    else $error("curve none did not give zero");

  a_linear_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_curve == ecv_pkg::CRV_LINEAR && in_position <= 16'd32768)
      |-> ##7 (out_eased == $past({1'b0, in_position}, 7)))
    else $error("linear curve did not return its position");

endmodule

bind easing_curve_evaluator ecv_checker u_ecv_checker (.*);

### test/tb_easing_curve_evaluator.sv
// self-checking testbench for the easing curve evaluator: directed sweep, then random words
module tb_easing_curve_evaluator;

  localparam int     LATENCY        = 7;
  localparam int     RANDOM_WORDS   = 550;
  localparam int     WATCHDOG_LIMIT = 500;
  localparam int     DRAIN_LIMIT    = 200;
  localparam longint ONE            = longint'(1) << ecv_pkg::FRAC_BITS;
  localparam longint HALF           = ONE >>> 1;

  // curve codes with no curve of their own fall back to linear
  localparam logic [ecv_pkg::CURVE_W-1:0] CRV_SPARE_FIRST = 4'd9;
  localparam logic [ecv_pkg::CURVE_W-1:0] CRV_SPARE_LAST  = 4'd15;

  localparam logic [ecv_pkg::EASED_W-1:0] E_ZERO = '0;
  localparam logic [ecv_pkg::EASED_W-1:0] E_UNIT = ecv_pkg::EASED_W'(ONE);

  typedef struct packed {
    logic [ecv_pkg::POS_W-1:0]   pos;
    logic [ecv_pkg::CURVE_W-1:0] crv;
    logic                        fixed;
    logic [ecv_pkg::EASED_W-1:0] want;
  } vector_t;

  typedef struct {
    logic [ecv_pkg::POS_W-1:0]   pos;
    logic [ecv_pkg::CURVE_W-1:0] crv;
    logic [ecv_pkg::EASED_W-1:0] eased;
  } eased_due_t;

  logic                                clk;
  logic                                rst_n       = 1'b0;
  logic                                start       = 1'b0;
  logic                                busy;
  logic [ecv_pkg::POS_W-1:0]           in_position = '0;
  logic [ecv_pkg::CURVE_W-1:0]         in_curve    = '0;
  logic                                out_valid;
  logic signed [ecv_pkg::EASED_W-1:0]  out_eased;

  // typed-in expectation that travels with the word being offered
  logic                                cue_fixed   = 1'b0;
  logic [ecv_pkg::EASED_W-1:0]         cue_want    = '0;

  eased_due_t eased_due[$];
  int         mismatches  = 0;
  int         quiet_cycles = 0;

  // directed sweep: extremes, every curve, saturation, segment splits, spare codes
  vector_t sweep [26] = '{
    '{16'h0000, ecv_pkg::CRV_NONE,        1'b1, E_ZERO},
    '{16'hFFFF, ecv_pkg::CRV_NONE,        1'b1, E_ZERO},
    '{16'h0000, ecv_pkg::CRV_LINEAR,      1'b1, E_ZERO},
    '{16'h8000, ecv_pkg::CRV_LINEAR,      1'b1, E_UNIT},
    '{16'hFFFF, ecv_pkg::CRV_LINEAR,      1'b1, E_UNIT},
    '{16'h8001, ecv_pkg::CRV_LINEAR,      1'b1, E_UNIT},
    '{16'h0000, ecv_pkg::CRV_EASE_IN,     1'b1, E_ZERO},
    '{16'h8000, ecv_pkg::CRV_EASE_IN,     1'b1, E_UNIT},
    '{16'h0000, ecv_pkg::CRV_EASE_OUT,    1'b1, E_ZERO},
    '{16'h8000, ecv_pkg::CRV_EASE_OUT,    1'b1, E_UNIT},
    '{16'h3FFF, ecv_pkg::CRV_EASE_BOTH,   1'b0, E_ZERO},
    '{16'h4000, ecv_pkg::CRV_EASE_BOTH,   1'b0, E_ZERO},
    '{16'h8000, ecv_pkg::CRV_EASE_BOTH,   1'b1, E_UNIT},
    '{16'h0000, ecv_pkg::CRV_BOUNCE_IN,   1'b0, E_ZERO},
    '{16'h5174, ecv_pkg::CRV_BOUNCE_IN,   1'b0, E_ZERO},
    '{16'h8000, ecv_pkg::CRV_BOUNCE_IN,   1'b0, E_ZERO},
    '{16'h2E8C, ecv_pkg::CRV_BOUNCE_OUT,  1'b0, E_ZERO},
    '{16'h5D17, ecv_pkg::CRV_BOUNCE_OUT,  1'b0, E_ZERO},
    '{16'h745D, ecv_pkg::CRV_BOUNCE_OUT,  1'b0, E_ZERO},
    '{16'h8000, ecv_pkg::CRV_BOUNCE_OUT,  1'b0, E_ZERO},
    '{16'h0000, ecv_pkg::CRV_SPRING_IN,   1'b1, E_ZERO},
    '{16'h2666, ecv_pkg::CRV_SPRING_IN,   1'b0, E_ZERO},
    '{16'h599A, ecv_pkg::CRV_SPRING_OUT,  1'b0, E_ZERO},
    '{16'h8000, ecv_pkg::CRV_SPRING_OUT,  1'b1, E_UNIT},
    '{16'h1234, CRV_SPARE_FIRST,          1'b1, ecv_pkg::EASED_W'(16'h1234)},
    '{16'hFFFF, CRV_SPARE_LAST,           1'b1, E_UNIT}
  };

  easing_curve_evaluator DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_position (in_position),
    .in_curve    (in_curve),
    .out_valid   (out_valid),
    .out_eased   (out_eased)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint fx_const(input longint num, input longint den);
    return ((num <<< ecv_pkg::FRAC_BITS) + den / 2) / den;
  endfunction

  // product back to the fixed-point format, halves rounded away from zero
  function automatic longint fx_mul(input longint a, input longint b);
    longint p;
    p = a * b;
    if (p >= 0)
      return (p + HALF) >>> ecv_pkg::FRAC_BITS;
    return -(((-p) + HALF) >>> ecv_pkg::FRAC_BITS);
  endfunction

  function automatic longint bounce_height(input longint x);
    longint centre;
    longint lift;
    longint d;
    if (x < fx_const(4, 11))
      return fx_mul(fx_const(121, 16), fx_mul(x, x));
    if (x < fx_const(8, 11)) begin
      centre = fx_const(6, 11);
      lift   = fx_const(3, 4);
    end else if (x < fx_const(10, 11)) begin
      centre = fx_const(9, 11);
      lift   = fx_const(15, 16);
    end else begin
      centre = fx_const(21, 22);
      lift   = fx_const(63, 64);
    end
    d = x - centre;
    return fx_mul(fx_const(121, 16), fx_mul(d, d)) + lift;
  endfunction

  // dips to -0.3 over the first 0.3, then climbs to 1.0 on a square law
  function automatic longint spring_height(input longint x);
    longint r;
    if (x < fx_const(3, 10)) begin
      r = fx_mul(x, fx_const(10, 3));
      r = ONE - fx_mul(ONE - r, ONE - r);
      return -fx_mul(r, fx_const(3, 10));
    end
    r = fx_mul(x - fx_const(3, 10), fx_const(10, 7));
    r = fx_mul(r, r);
    return fx_mul(r, fx_const(13, 10)) - fx_const(3, 10);
  endfunction

  function automatic logic [ecv_pkg::EASED_W-1:0] ease_value(
      input logic [ecv_pkg::POS_W-1:0] pos, input logic [ecv_pkg::CURVE_W-1:0] crv);
    longint t;
    longint inv;
    longint c;
    longint v;
    t = longint'(pos);
    if (t > ONE)
      t = ONE;
    inv = ONE - t;
    case (crv)
      ecv_pkg::CRV_NONE:       v = 0;
      ecv_pkg::CRV_EASE_IN:    v = fx_mul(t, t);
      ecv_pkg::CRV_EASE_OUT:   v = ONE - fx_mul(inv, inv);
      ecv_pkg::CRV_EASE_BOTH: begin
        if (t < HALF) begin
          v = fx_mul(2 * t, t);
        end else begin
          c = 2 * (t - HALF);
          c = ONE - fx_mul(ONE - c, ONE - c);
          v = ((c + 1) >>> 1) + HALF;
        end
      end
      ecv_pkg::CRV_BOUNCE_IN:  v = ONE - bounce_height(inv);
      ecv_pkg::CRV_BOUNCE_OUT: v = bounce_height(t);
      ecv_pkg::CRV_SPRING_IN:  v = spring_height(t);
      ecv_pkg::CRV_SPRING_OUT: v = ONE - spring_height(inv);
      default:                 v = t;
    endcase
    return v[ecv_pkg::EASED_W-1:0];
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic int settle_gap(input bit calm);
    if (calm || $urandom_range(0, 99) >= 20)
      return 0;
    return $urandom_range(1, 2);
  endfunction

  // mostly in range, some saturated, some hugging a segment boundary
  function automatic logic [ecv_pkg::POS_W-1:0] pick_position();
    longint anchor [8];
    longint p;
    int     k;
    anchor[0] = 0;
    anchor[1] = HALF;
    anchor[2] = ONE;
    anchor[3] = fx_const(4, 11);
    anchor[4] = fx_const(8, 11);
    anchor[5] = fx_const(10, 11);
    anchor[6] = fx_const(3, 10);
    anchor[7] = ONE - fx_const(3, 10);
    k = $urandom_range(0, 99);
    if (k < 70)
      return ecv_pkg::POS_W'($urandom_range(0, 32'(ONE)));
    if (k < 82)
      return ecv_pkg::POS_W'($urandom_range(0, (1 << ecv_pkg::POS_W) - 1));
    p = anchor[$urandom_range(0, 7)] + longint'($urandom_range(0, 6)) - 3;
    if ($urandom_range(0, 1))
      p = ONE - p;
    if (p < 0)
      p = 0;
    return p[ecv_pkg::POS_W-1:0];
  endfunction

  function automatic logic [ecv_pkg::CURVE_W-1:0] pick_curve();
    if ($urandom_range(0, 99) < 85)
      return ecv_pkg::CURVE_W'($urandom_range(0, int'(ecv_pkg::CRV_SPRING_OUT)));
    return ecv_pkg::CURVE_W'($urandom_range(0, (1 << ecv_pkg::CURVE_W) - 1));
  endfunction

  // called just after a rising edge; returns just after the edge that took the word
  task automatic offer_word(input logic [ecv_pkg::POS_W-1:0] pos,
                            input logic [ecv_pkg::CURVE_W-1:0] crv,
                            input logic fixed, input logic [ecv_pkg::EASED_W-1:0] want,
                            input int gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_position <= pos;
    in_curve    <= crv;
    cue_fixed   <= fixed;
    cue_want    <= want;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic log_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------- scoreboard

  // taken words and shown results are both handled here, so their order at one edge is fixed
  eased_due_t due_head;
  eased_due_t due_new;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (eased_due.size() == 0) begin
          log_mismatch($sformatf("result %0d with no word outstanding", out_eased));
        end else begin
          due_head = eased_due.pop_front();
          if (out_eased !== due_head.eased)
            log_mismatch($sformatf("t=%h curve=%0d eased=%0d want %0d", due_head.pos,
                                   due_head.crv, out_eased, $signed(due_head.eased)));
        end
      end
      if (start && busy === 1'b0) begin
        due_new.pos   = in_position;
        due_new.crv   = in_curve;
        due_new.eased = cue_fixed ? cue_want : ease_value(in_position, in_curve);
        eased_due.push_back(due_new);
      end
    end
  end

  // no word taken and no result shown for too long means the block has hung
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("easing_curve_evaluator regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    int i;
    int w;
    bit calm;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < $size(sweep); i++)
      offer_word(sweep[i].pos, sweep[i].crv, sweep[i].fixed, sweep[i].want,
                 settle_gap(1'b0));

    for (i = 0; i < RANDOM_WORDS; i++) begin
      // back-to-back stretch with no sender gaps
      calm = (i >= 200 && i < 320);
      if (i == 400) begin
        // let the pipeline empty completely before going on
        start <= 1'b0;
        do @(posedge clk); while (eased_due.size() != 0);
        offer_word(pick_position(), pick_curve(), 1'b0, E_ZERO, 0);
      end else begin
        offer_word(pick_position(), pick_curve(), 1'b0, E_ZERO, settle_gap(calm));
      end
    end
    start <= 1'b0;

    for (w = 0; w < DRAIN_LIMIT && eased_due.size() != 0; w++)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (eased_due.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", eased_due.size()));

    if (mismatches == 0)
      $display("easing_curve_evaluator regression: pass");
    else
      $display("easing_curve_evaluator regression: fail");
    $finish;
  end

endmodule

### easing_curve_evaluator.f
hdl/ecv_pkg.sv
hdl/ecv_mul.sv
hdl/easing_curve_evaluator.sv
hdl/ecv_checker.sv
test/tb_easing_curve_evaluator.sv
